// ===== hw/rtl/kehr_pkg.sv =====
// Shared types, constants and the key code to HID usage table.
package kehr_pkg;

    localparam int unsigned TYPE_W   = 16;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned USAGE_W  = 8;
    localparam int unsigned OUT_SLOTS = 6;
    localparam int unsigned IN_DATA_W  = TYPE_W + CODE_W + VALUE_W;
    localparam int unsigned OUT_DATA_W = OUT_SLOTS * USAGE_W;

    localparam logic [TYPE_W-1:0]  KEY_EVENT_TYPE = 16'd1;
    localparam logic [VALUE_W-1:0] KEY_PRESSED    = 32'd1;
    localparam logic [VALUE_W-1:0] KEY_RELEASED   = 32'd0;
    localparam logic [CODE_W-1:0]  ROM_SIZE       = 16'd101;
    localparam int unsigned        ROM_IDX_W      = 7;

    // Decoded key action handed to the slot stage
    typedef struct packed {
        logic                press;
        logic                release_key;
        logic [USAGE_W-1:0]  usage;
    } t_key_op;

    typedef logic [OUT_SLOTS-1:0][USAGE_W-1:0] t_report;

    // evdev key code to HID keyboard usage; zero means no usage
    function automatic logic [USAGE_W-1:0] usage_lookup(input logic [ROM_IDX_W-1:0] code);
        logic [USAGE_W-1:0] u;
        case (code)
            7'd1:   u = 8'd41;
            7'd2:   u = 8'd30;
            7'd3:   u = 8'd31;
            7'd4:   u = 8'd32;
            7'd5:   u = 8'd33;
            7'd6:   u = 8'd34;
            7'd7:   u = 8'd35;
            7'd8:   u = 8'd36;
            7'd9:   u = 8'd37;
            7'd10:  u = 8'd38;
            7'd11:  u = 8'd39;
            7'd12:  u = 8'd45;
            7'd13:  u = 8'd46;
            7'd14:  u = 8'd42;
            7'd15:  u = 8'd43;
            7'd16:  u = 8'd20;
            7'd17:  u = 8'd26;
            7'd18:  u = 8'd8;
            7'd19:  u = 8'd21;
            7'd20:  u = 8'd23;
            7'd21:  u = 8'd28;
            7'd22:  u = 8'd24;
            7'd23:  u = 8'd12;
            7'd24:  u = 8'd18;
            7'd25:  u = 8'd19;
            7'd26:  u = 8'd47;
            7'd27:  u = 8'd48;
            7'd28:  u = 8'd40;
            7'd29:  u = 8'd224;
            7'd30:  u = 8'd4;
            7'd31:  u = 8'd22;
            7'd32:  u = 8'd7;
            7'd33:  u = 8'd9;
            7'd34:  u = 8'd10;
            7'd35:  u = 8'd11;
            7'd36:  u = 8'd13;
            7'd37:  u = 8'd14;
            7'd38:  u = 8'd15;
            7'd39:  u = 8'd51;
            7'd40:  u = 8'd52;
            7'd41:  u = 8'd53;
            7'd42:  u = 8'd225;
            7'd43:  u = 8'd49;
            7'd44:  u = 8'd29;
            7'd45:  u = 8'd27;
            7'd46:  u = 8'd6;
            7'd47:  u = 8'd25;
            7'd48:  u = 8'd5;
            7'd49:  u = 8'd17;
            7'd50:  u = 8'd16;
            7'd51:  u = 8'd54;
            7'd52:  u = 8'd55;
            7'd53:  u = 8'd56;
            7'd54:  u = 8'd229;
            7'd55:  u = 8'd85;
            7'd56:  u = 8'd226;
            7'd57:  u = 8'd44;
            7'd58:  u = 8'd57;
            7'd59:  u = 8'd58;
            7'd60:  u = 8'd59;
            7'd61:  u = 8'd60;
            7'd62:  u = 8'd61;
            7'd63:  u = 8'd62;
            7'd64:  u = 8'd63;
            7'd65:  u = 8'd64;
            7'd66:  u = 8'd65;
            7'd67:  u = 8'd66;
            7'd68:  u = 8'd67;
            7'd69:  u = 8'd83;
            7'd70:  u = 8'd71;
            7'd71:  u = 8'd95;
            7'd72:  u = 8'd96;
            7'd73:  u = 8'd97;
            7'd74:  u = 8'd86;
            7'd75:  u = 8'd92;
            7'd76:  u = 8'd93;
            7'd77:  u = 8'd94;
            7'd78:  u = 8'd87;
            7'd79:  u = 8'd89;
            7'd80:  u = 8'd90;
            7'd81:  u = 8'd91;
            7'd82:  u = 8'd98;
            7'd83:  u = 8'd99;
            7'd97:  u = 8'd228;
            7'd100: u = 8'd230;
            default: u = 8'd0;
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/kehr_decode.sv =====
// Input stage: classifies the key event, looks up its usage and registers the action.
module kehr_decode import kehr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_advance,
    output logic                 o_ready,
    output logic                 o_op_valid,
    output t_key_op              o_op
);

    logic [TYPE_W-1:0]  w_type;
    logic [CODE_W-1:0]  w_code;
    logic [VALUE_W-1:0] w_value;
    logic [USAGE_W-1:0] w_usage;
    logic               w_key_ok;
    t_key_op            n_op;
    logic               r_valid;
    t_key_op            r_op;

    assign w_type  = i_data[TYPE_W-1:0];
    assign w_code  = i_data[TYPE_W +: CODE_W];
    assign w_value = i_data[TYPE_W+CODE_W +: VALUE_W];

    // table lookup and event filter
    always_comb begin
        w_usage  = usage_lookup(w_code[ROM_IDX_W-1:0]);
        w_key_ok = (w_type == KEY_EVENT_TYPE) && (w_code != '0) && (w_code < ROM_SIZE)
                   && (w_usage != '0);
        n_op.usage       = w_usage;
        n_op.press       = w_key_ok && (w_value == KEY_PRESSED);
        n_op.release_key = w_key_ok && (w_value == KEY_RELEASED);
    end

    // stage register moves whenever it is empty or the next stage takes it
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_op <= n_op;
        end
    end

    assign o_op_valid = r_valid;
    assign o_op       = r_op;

endmodule

// ===== hw/rtl/kehr_slots.sv =====
// Held usage slots: press insert, release remove with shift down, result register.
module kehr_slots import kehr_pkg::*; #(
    parameter int unsigned SLOT_COUNT = 6
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_op_valid,
    input  t_key_op  i_op,
    input  logic     i_advance,
    output logic     o_valid,
    output t_report  o_report,
    output logic     o_changed
);

    typedef logic [SLOT_COUNT-1:0][USAGE_W-1:0] t_slots;

    t_slots                r_slots;
    t_slots                n_slots;
    t_slots                w_shift;
    logic                  r_valid;
    logic                  r_changed;
    logic                  n_changed;
    logic [SLOT_COUNT-1:0] w_match;
    logic [SLOT_COUNT-1:0] w_zero;
    logic [SLOT_COUNT-1:0] w_first_free;
    logic [SLOT_COUNT-1:0] w_from_hit;

    // per-slot compares, first free slot and the slots from the hit onward
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_match[i] = (r_slots[i] == i_op.usage);
            w_zero[i]  = (r_slots[i] == '0);
        end
        // slots stay packed, so the first free one follows an occupied one
        w_first_free[0] = w_zero[0];
        w_from_hit[0]   = w_match[0];
        for (int i = 1; i < SLOT_COUNT; i++) begin
            w_first_free[i] = w_zero[i] && !w_zero[i-1];
            w_from_hit[i]   = w_match[i] || w_from_hit[i-1];
        end
        for (int i = 0; i < SLOT_COUNT - 1; i++) begin
            w_shift[i] = r_slots[i+1];
        end
        w_shift[SLOT_COUNT-1] = '0;
    end

    // next slot contents
    always_comb begin
        n_slots   = r_slots;
        n_changed = 1'b0;
        if (i_op.press && !(|w_match) && (|w_zero)) begin
            n_changed = 1'b1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (w_first_free[i]) begin
                    n_slots[i] = i_op.usage;
                end
            end
        end else if (i_op.release_key && (|w_match)) begin
            n_changed = 1'b1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (w_from_hit[i]) begin
                    n_slots[i] = w_shift[i];
                end
            end
        end
    end

    // slot state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_slots   <= '0;
            r_changed <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_op_valid;
            if (i_op_valid) begin
                r_slots   <= n_slots;
                r_changed <= n_changed;
            end
        end
    end

    // reported slots beyond the slot count read zero
    for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_out
        if (j < SLOT_COUNT) begin : g_held
            assign o_report[j] = r_slots[j];
        end else begin : g_empty
            assign o_report[j] = '0;
        end
    end

    assign o_valid   = r_valid;
    assign o_changed = r_changed;

endmodule

// ===== hw/rtl/key_event_to_hid_rollover_report_core.sv =====
// Top level: key event stream in, six-key rollover report stream out.

// Each accepted key event beat yields exactly one report beat, passing through the
// decode register (usage table lookup and event filter) and then the slot register
// (six parallel usage compares and a one-step shift down). A new event is taken
// every cycle unless the output stalls; the slot register is the only state
// carried from one event to the next. Events that are not key presses or releases
// of a mapped code still give a report, with report_changed low. Modifier keys
// occupy ordinary slots; no modifier byte is built.
module key_event_to_hid_rollover_report_core import kehr_pkg::*; #(
    parameter int unsigned SLOT_COUNT = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [15:0] event_type, [31:16] key_code, [63:32] key_value
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] usage_slot_0, [15:8] usage_slot_1 ... [47:40] usage_slot_5
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] report_changed
    output logic                  o_m_axis_tuser
);

    logic    w_advance;
    logic    w_op_valid;
    t_key_op w_op;
    t_report w_report;
    logic    w_packed;

    // result register frees when empty or taken
    assign w_advance = !o_m_axis_tvalid || i_m_axis_tready;

    kehr_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_data     (i_s_axis_tdata),
        .i_advance  (w_advance),
        .o_ready    (o_s_axis_tready),
        .o_op_valid (w_op_valid),
        .o_op       (w_op)
    );

    kehr_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .i_advance  (w_advance),
        .o_valid    (o_m_axis_tvalid),
        .o_report   (w_report),
        .o_changed  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = w_report;

    // no held usage after an empty slot
    always_comb begin
        w_packed = 1'b1;
        for (int i = 0; i < OUT_SLOTS - 1; i++) begin
            if (w_report[i] == '0 && w_report[i+1] != '0) begin
                w_packed = 1'b0;
            end
        end
    end

    a_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n) w_packed)
        else $error("report slots not packed from slot 0");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (w_op_valid && o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled while a stage was free");

    a_result_from_event : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_op_valid))
        else $error("report beat without a decoded event");

    a_unchanged_report : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_op_valid && !w_op.press && !w_op.release_key)
        |=> (!o_m_axis_tuser && $stable(o_m_axis_tdata)))
        else $error("ignored event altered the report");

endmodule
